/* rtl/vrs_pkg.sv */
// Package with the widths, limits and register map of the climb-rate slope unit.
package vrs_pkg;

  localparam int HISTORY_LEN  = 10;
  localparam int DELTA_T_BITS = 20;

  localparam int ALT_W   = 21;
  localparam int TS_W    = 32;
  localparam int CLIMB_W = 18;
  localparam int WIN_W   = 4;

  localparam int CNT_W = $clog2(HISTORY_LEN + 1);
  localparam int X_W   = DELTA_T_BITS;
  localparam int NX_W  = X_W + WIN_W;
  localparam int SX_W  = X_W + CNT_W;
  localparam int SY_W  = ALT_W + CNT_W;

  localparam int MUL_A_W = (SX_W + 1 > SY_W) ? SX_W + 1 : SY_W;
  localparam int MUL_W   = (NX_W + 1 > MUL_A_W) ? NX_W + 1 : MUL_A_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + CNT_W;
  localparam int NUM_W   = ACC_W + 1;

  localparam int Q_W     = 18;
  localparam int QCNT_W  = $clog2(Q_W);
  localparam int DIV_W   = NUM_W + Q_W;

  localparam int CLIMB_LIMIT = 100000;
  localparam logic [TS_W-1:0] DT_MAX = TS_W'((64'd1 << DELTA_T_BITS) - 64'd1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_COUNT = '0;

endpackage

/* rtl/vrs_in_if.sv */
// Input channel carrying one altitude sample and its timestamp per item.
interface vrs_in_if import vrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ALT_W-1:0]  altitude_cm;
  logic        [TS_W-1:0]   timestamp_ms;

  modport source (output valid, output altitude_cm, output timestamp_ms, input ready);
  modport sink   (input valid, input altitude_cm, input timestamp_ms, output ready);
endinterface

/* rtl/vrs_out_if.sv */
// Result channel carrying the climb rate and the degenerate-fit flag per item.
interface vrs_out_if import vrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [CLIMB_W-1:0] climb_rate;
  logic                      degenerate;

  modport source (output valid, output climb_rate, output degenerate, input ready);
  modport sink   (input valid, input climb_rate, input degenerate, output ready);
endinterface

/* rtl/vario_regression_slope_unit.sv */
// Top level of the least-squares climb-rate unit with its sequencer and shared datapath.
//
// Each input item carries an altitude sample in cm and its millisecond timestamp.
// The sample is pushed into an 11-entry history and a least-squares line is fitted
// through the window_count entries (at most 10) just older than the newest one. The result item
// carries the slope in cm/s (1000 times the cm/ms slope), saturated to +-100000, and a degenerate flag
// that is set, with a zero climb rate, when the fit has no solution.
// One item is worked on at a time; in_if.ready is high only while the unit is idle.
// A shared 25x25 multiplier works on each of the n window entries in the states S_FETCH,
// S_NX, S_NXY, S_NXX and S_ACC, and a restoring divider then produces one quotient bit per
// cycle of an 18-bit quotient; a degenerate fit skips the division. After the result is
// loaded into the output register the sequencer returns to idle, where it accepts the next item.
// The result waits in the output register while the receiver stalls; the unit may
// finish the next item meanwhile and then holds it until the register frees up.
// window_count is written over the APB-style port at byte address 0 and resets to 8.
// The synchronous reset clears the history to zero and returns the sequencer to idle.
module vario_regression_slope_unit import vrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vrs_in_if.sink                in_if,
  vrs_out_if.source             out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_T0, S_FETCH, S_NX, S_NXY, S_NXX, S_ACC,
    S_SXY, S_SXX, S_DEN, S_PREP, S_SCALE, S_DIV, S_DONE
  } state_t;

  state_t                    state_r;
  logic [WIN_W-1:0]          window_r;
  logic signed [ALT_W-1:0]   alt_hist_r [0:HISTORY_LEN];
  logic [TS_W-1:0]           time_hist_r [0:HISTORY_LEN];
  logic [WIN_W-1:0]          n_r;
  logic [CNT_W-1:0]          idx_r;
  logic [TS_W-1:0]           t0_r;
  logic [X_W-1:0]            x_r;
  logic signed [ALT_W-1:0]   y_r;
  logic [NX_W-1:0]           nx_r;
  logic [SX_W-1:0]           sx_r;
  logic signed [SY_W-1:0]    sy_r;
  logic signed [ACC_W-1:0]   nsxy_r;
  logic signed [ACC_W-1:0]   nsxx_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [NUM_W-1:0]   num_r;
  logic signed [NUM_W-1:0]   den_r;
  logic                      neg_r;
  logic                      degen_r;
  logic [DIV_W-1:0]          rem_r;
  logic [DIV_W-1:0]          dsh_r;
  logic [Q_W-1:0]            q_r;
  logic [QCNT_W-1:0]         qcnt_r;
  logic                      out_valid_r;
  logic signed [CLIMB_W-1:0] out_climb_r;
  logic                      out_degen_r;

  logic                      in_fire;
  logic                      cfg_write;
  logic [WIN_W-1:0]          n_nxt;
  logic [TS_W-1:0]           dt;
  logic [X_W-1:0]            x_fetch;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]          mag_abs;
  logic                      div_ge;
  logic [Q_W-1:0]            climb_mag;
  logic signed [CLIMB_W-1:0] climb_val;

  assign in_fire    = in_if.valid && in_if.ready;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_COUNT)
                      ? CFG_DATA_W'(window_r) : '0;

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.climb_rate = out_climb_r;
  assign out_if.degenerate = out_degen_r;

  assign n_nxt   = (int'(window_r) > HISTORY_LEN) ? WIN_W'(HISTORY_LEN) : window_r;
  assign dt      = time_hist_r[idx_r] - t0_r;
  assign x_fetch = (dt > DT_MAX) ? X_W'(DT_MAX) : dt[X_W-1:0];
  assign mag_abs = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign div_ge  = (rem_r >= dsh_r);

  assign climb_mag = (q_r > Q_W'(CLIMB_LIMIT)) ? Q_W'(CLIMB_LIMIT) : q_r;
  assign climb_val = neg_r ? -CLIMB_W'(climb_mag) : CLIMB_W'(climb_mag);

  always_comb begin
    mul_a = MUL_W'(x_r);
    mul_b = MUL_W'(n_r);
    case (state_r)
      S_NXY: begin
        mul_a = MUL_W'(prod_r[NX_W-1:0]);
        mul_b = MUL_W'(y_r);
      end
      S_NXX: begin
        mul_a = MUL_W'(nx_r);
        mul_b = MUL_W'(x_r);
      end
      S_SXY: begin
        mul_a = MUL_W'(sx_r);
        mul_b = MUL_W'(sy_r);
      end
      S_SXX: begin
        mul_a = MUL_W'(sx_r);
        mul_b = MUL_W'(sx_r);
      end
      default: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(n_r);
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WINDOW_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= HISTORY_LEN; i++) begin
        alt_hist_r[i]  <= '0;
        time_hist_r[i] <= '0;
      end
    end else begin
      if (cfg_write && cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_COUNT) begin
        window_r <= cfg_pwdata[WIN_W-1:0];
      end
      if (out_valid_r && out_if.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            for (int i = 0; i < HISTORY_LEN; i++) begin
              alt_hist_r[i]  <= alt_hist_r[i+1];
              time_hist_r[i] <= time_hist_r[i+1];
            end
            alt_hist_r[HISTORY_LEN]  <= in_if.altitude_cm;
            time_hist_r[HISTORY_LEN] <= in_if.timestamp_ms;
            n_r     <= n_nxt;
            idx_r   <= CNT_W'(HISTORY_LEN) - CNT_W'(n_nxt);
            sx_r    <= '0;
            sy_r    <= '0;
            nsxy_r  <= '0;
            nsxx_r  <= '0;
            q_r     <= '0;
            degen_r <= 1'b0;
            state_r <= S_T0;
          end
        end
        S_T0: begin
          t0_r    <= time_hist_r[idx_r];
          state_r <= (n_r == '0) ? S_SXY : S_FETCH;
        end
        S_FETCH: begin
          x_r     <= x_fetch;
          y_r     <= alt_hist_r[idx_r];
          state_r <= S_NX;
        end
        S_NX: begin
          sx_r    <= sx_r + SX_W'(x_r);
          sy_r    <= sy_r + SY_W'(y_r);
          state_r <= S_NXY;
        end
        S_NXY: begin
          nx_r    <= prod_r[NX_W-1:0];
          state_r <= S_NXX;
        end
        S_NXX: begin
          nsxy_r  <= nsxy_r + ACC_W'(prod_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          nsxx_r <= nsxx_r + ACC_W'(prod_r);
          if (idx_r == CNT_W'(HISTORY_LEN - 1)) begin
            state_r <= S_SXY;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FETCH;
          end
        end
        S_SXY: begin
          state_r <= S_SXX;
        end
        S_SXX: begin
          num_r   <= NUM_W'(nsxy_r) - NUM_W'(prod_r);
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r   <= NUM_W'(nsxx_r) - NUM_W'(prod_r);
          state_r <= S_PREP;
        end
        S_PREP: begin
          neg_r <= num_r[NUM_W-1];
          if (den_r[NUM_W-1] || den_r == '0) begin
            degen_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            rem_r   <= DIV_W'(mag_abs);
            dsh_r   <= DIV_W'(den_r) << (Q_W - 1);
            qcnt_r  <= QCNT_W'(Q_W - 1);
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          // Scale the dividend by 1000 as 1024 - 32 + 8.
          rem_r   <= (rem_r << 10) - (rem_r << 5) + (rem_r << 3);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[Q_W-2:0], div_ge};
          dsh_r <= dsh_r >> 1;
          if (qcnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            qcnt_r <= qcnt_r - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_climb_r <= degen_r ? '0 : climb_val;
            out_degen_r <= degen_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The least-squares denominator can never be negative.
  a_den_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREP |-> !den_r[NUM_W-1])
    else $error("negative regression denominator");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> idx_r < CNT_W'(HISTORY_LEN))
    else $error("window index beyond the fitted entries");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the done state");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |-> out_climb_r == '0)
    else $error("degenerate item with nonzero climb rate");

endmodule

/* verif/vario_regression_slope_checker.sv */
// Checker that watches the channels of the climb-rate slope unit, predicts each result and compares.
`timescale 1ns / 100ps

module vario_regression_slope_checker import vrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vrs_in_if                     in_mon,
  vrs_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatch_count,
  output int                    pending_results
);

  typedef struct packed {
    logic signed [CLIMB_W-1:0] climb_rate;
    logic                      degenerate;
  } climb_result_t;

  logic signed [ALT_W-1:0] alt_hist [0:HISTORY_LEN];
  logic        [TS_W-1:0]  ts_hist  [0:HISTORY_LEN];
  logic        [WIN_W-1:0] window_setting;
  climb_result_t           expected_climb_q [$];
  int                      error_tally = 0;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic void predict_climb(input logic [WIN_W-1:0] win,
                                        output logic signed [CLIMB_W-1:0] climb,
                                        output logic degen);
    int n;
    int first;
    logic [TS_W-1:0] t0;
    logic [TS_W-1:0] dt;
    longint x, y, sxy, sx, sy, sxx, num, den, mag, rem;
    sxy = 0;
    sx  = 0;
    sy  = 0;
    sxx = 0;
    n = (win > HISTORY_LEN) ? HISTORY_LEN : int'(win);
    first = HISTORY_LEN - n;
    t0 = ts_hist[first];
    for (int i = first; i < HISTORY_LEN; i++) begin
      dt = ts_hist[i] - t0;
      if (dt > DT_MAX) dt = DT_MAX;
      x = longint'(dt);
      y = longint'(alt_hist[i]);
      sxy += x * y;
      sx  += x;
      sy  += y;
      sxx += x * x;
    end
    num = n * sxy - sx * sy;
    den = n * sxx - sx * sx;
    if (den <= 0) begin
      degen = 1'b1;
      climb = '0;
    end else begin
      degen = 1'b0;
      mag = (num < 0) ? -num : num;
      rem = mag % den;
      mag = mag / den;
      if (mag > CLIMB_LIMIT / 1000) begin
        mag = CLIMB_LIMIT;
      end else begin
        repeat (3) begin
          rem = rem * 10;
          mag = mag * 10 + rem / den;
          rem = rem % den;
        end
        if (mag > CLIMB_LIMIT) mag = CLIMB_LIMIT;
      end
      climb = (num < 0) ? CLIMB_W'(-mag) : CLIMB_W'(mag);
    end
  endfunction

  always @(posedge clk) begin
    climb_result_t got;
    climb_result_t want;
    logic signed [CLIMB_W-1:0] climb;
    logic degen;
    if (!rst_n) begin
      for (int i = 0; i <= HISTORY_LEN; i++) begin
        alt_hist[i] = '0;
        ts_hist[i]  = '0;
      end
      window_setting = WINDOW_RESET;
      expected_climb_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_COUNT) begin
        window_setting = cfg_pwdata[WIN_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got.climb_rate = out_mon.climb_rate;
        got.degenerate = out_mon.degenerate;
        if (expected_climb_q.size() == 0) begin
          $display("%0t: result with none expected, actual climb_rate %0d degenerate %0b",
                   $time, $signed(got.climb_rate), got.degenerate);
          error_tally++;
        end else begin
          want = expected_climb_q.pop_front();
          if (got.climb_rate !== want.climb_rate) begin
            $display("%0t: climb_rate expected %0d, actual %0d", $time,
                     $signed(want.climb_rate), $signed(got.climb_rate));
            error_tally++;
          end
          if (got.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b, actual %0b", $time,
                     want.degenerate, got.degenerate);
            error_tally++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        for (int i = 1; i <= HISTORY_LEN; i++) begin
          alt_hist[i-1] = alt_hist[i];
          ts_hist[i-1]  = ts_hist[i];
        end
        alt_hist[HISTORY_LEN] = in_mon.altitude_cm;
        ts_hist[HISTORY_LEN]  = in_mon.timestamp_ms;
        predict_climb(window_setting, climb, degen);
        want.climb_rate = climb;
        want.degenerate = degen;
        expected_climb_q.push_back(want);
      end
    end
    pending_results <= expected_climb_q.size();
    mismatch_count  <= error_tally;
  end

endmodule

/* verif/vario_regression_slope_unit_tb.sv */
// Testbench top that drives samples and window settings into the climb-rate unit and reports.
`timescale 1ns / 100ps

module vario_regression_slope_unit_tb;
  import vrs_pkg::*;

  typedef enum int {STEADY_FLIGHT, SENSOR_NOISE, CLOCK_GLITCH} sample_mode_t;

  localparam logic signed [ALT_W-1:0] ALT_TOP    = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic signed [ALT_W-1:0] ALT_BOTTOM = {1'b1, {(ALT_W-1){1'b0}}};
  localparam int ALT_TOP_INT    = (1 << (ALT_W - 1)) - 1;
  localparam int ALT_BOTTOM_INT = -(1 << (ALT_W - 1));
  localparam logic [WIN_W-1:0] WINDOW_PLAN [8] = '{4'd2, 4'd10, 4'd15, 4'd0,
                                                   4'd1, 4'd3, 4'd9, 4'd5};
  localparam int SAMPLES_PER_PHASE = 135;
  localparam int DRAIN_CYCLES      = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    mismatch_count;
  int                    pending_results;
  int                    idle_pct;
  logic [TS_W-1:0]       flight_ts;
  int                    flight_alt;
  int                    climb_cmps;

  vrs_in_if  in_ch ();
  vrs_out_if out_ch ();

  vario_regression_slope_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  vario_regression_slope_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_stall_len();
    if ($urandom_range(9) == 0) return $urandom_range(120, 20);
    return $urandom_range(3, 1);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 6) begin
        stall_left = pick_stall_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic signed [ALT_W-1:0] alt, input logic [TS_W-1:0] ts);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat (pick_stall_len()) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.altitude_cm  <= alt;
    in_ch.timestamp_ms <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic fly_samples(input int count);
    sample_mode_t mode;
    int burst_left;
    int dt;
    logic signed [ALT_W-1:0] alt;
    logic [TS_W-1:0] ts;
    burst_left = 0;
    mode = STEADY_FLIGHT;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(99) < 75) mode = STEADY_FLIGHT;
        else if ($urandom_range(1) == 0) mode = SENSOR_NOISE;
        else mode = CLOCK_GLITCH;
        burst_left = (mode == STEADY_FLIGHT) ? $urandom_range(40, 10) : $urandom_range(6, 1);
        if ($urandom_range(7) == 0) flight_ts = $urandom;
        if ($urandom_range(1) == 0) climb_cmps = $urandom_range(4000) - 2000;
        else climb_cmps = $urandom_range(300000) - 150000;
      end
      burst_left--;
      case (mode)
        STEADY_FLIGHT: begin
          dt = $urandom_range(200, 20);
          flight_ts += dt;
          flight_alt += climb_cmps * dt / 1000 + int'($urandom_range(20)) - 10;
          if (flight_alt > ALT_TOP_INT) begin
            flight_alt = ALT_TOP_INT;
            climb_cmps = -climb_cmps;
          end else if (flight_alt < ALT_BOTTOM_INT) begin
            flight_alt = ALT_BOTTOM_INT;
            climb_cmps = -climb_cmps;
          end
          alt = ALT_W'(flight_alt);
          ts  = flight_ts;
        end
        SENSOR_NOISE: begin
          alt = ALT_W'($urandom);
          ts  = $urandom;
        end
        default: begin
          case ($urandom_range(2))
            0: flight_ts = flight_ts;
            1: flight_ts -= $urandom_range(5000, 1);
            default: flight_ts += $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
          endcase
          alt = ALT_W'(flight_alt);
          ts  = flight_ts;
        end
      endcase
      send_item(alt, ts);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] cfg_data;
    in_ch.valid        <= 1'b0;
    in_ch.altitude_cm  <= '0;
    in_ch.timestamp_ms <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    idle_pct   = 30;
    flight_ts  = '0;
    flight_alt = 0;
    climb_cmps = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Zeroed history, a steady climb, a steep dive, a timestamp wrap, a clock that
    // steps back and a gap beyond the time offset limit.
    send_item('0, 32'd0);
    send_item(ALT_TOP, 32'd0);
    send_item(ALT_BOTTOM, 32'd0);
    for (int k = 1; k <= 10; k++) send_item(ALT_W'(k * 1000), TS_W'(k * 100));
    for (int k = 1; k <= 4; k++) send_item(ALT_W'(10000 - k * 50000), TS_W'(1000 + k * 100));
    send_item(ALT_TOP, 32'hFFFF_FFF0);
    send_item(ALT_BOTTOM, 32'hFFFF_FFFF);
    send_item(ALT_W'(-5), 32'h0000_0010);
    send_item(ALT_W'(5), 32'h0000_0008);
    send_item(ALT_W'(7), 32'h8000_0000);
    fly_samples(SAMPLES_PER_PHASE);

    for (int p = 0; p < $size(WINDOW_PLAN); p++) begin
      wait_drained();
      cfg_data = $urandom;
      cfg_data[WIN_W-1:0] = WINDOW_PLAN[p];
      write_register(REG_WINDOW_COUNT, cfg_data);
      idle_pct = (p == 1) ? 0 : 30;
      fly_samples(SAMPLES_PER_PHASE);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
